### hdl/lss_pkg.sv
`default_nettype none

package lss_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_PUSH    = 3'd0;
    localparam logic [2:0] REQ_POP     = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_SEARCH  = 3'd3;
    localparam logic [2:0] REQ_DISPLAY = 3'd4;

    // Result kinds carried in result_kind.
    localparam logic [2:0] KIND_POPPED      = 3'd0;
    localparam logic [2:0] KIND_PEEKED      = 3'd1;
    localparam logic [2:0] KIND_EMPTY       = 3'd2;
    localparam logic [2:0] KIND_FULL        = 3'd3;
    localparam logic [2:0] KIND_MATCH_POS   = 3'd4;
    localparam logic [2:0] KIND_MATCH_COUNT = 3'd5;
    localparam logic [2:0] KIND_DISPLAY     = 3'd6;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_value;
    } t_req;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic signed [31:0] result_data;
        logic               display_end;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATUS,
        ST_ONE,
        ST_WALK,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        DATA_ZERO,
        DATA_MEM,
        DATA_POS,
        DATA_COUNT
    } t_data_sel;

    typedef struct packed {
        logic       load;       // latch the search key of an accepted request
        logic       push;       // write the operand on top, fill level up
        logic       pop;        // fill level down
        logic       start;      // aim the walk at the top entry
        logic       advance;    // step the walk one entry down
        logic       count_inc;  // one more match
        logic       emit;       // load the output register
        logic [2:0] kind;
        t_data_sel  data_sel;
        logic       dend;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic at_bottom;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### hdl/lss_ctrl.sv
`default_nettype none

module lss_ctrl
    import lss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [2:0] i_req_type,
    output logic            o_in_ready,
    input  wire t_status    i_status,
    output t_cmd            o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_req, n_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_req   <= REQ_PUSH;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
        end
    end

    always_comb begin
        logic need;
        need       = 1'b0;
        n_state    = r_state;
        n_req      = r_req;
        o_in_ready = (r_state == ST_IDLE);
        o_cmd      = '0;
        o_cmd.data_sel = DATA_ZERO;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_req      = i_req_type;
                    unique case (i_req_type)
                        REQ_PUSH: begin
                            if (i_status.full) begin
                                n_state = ST_STATUS;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        REQ_POP, REQ_PEEK: begin
                            if (i_status.empty) begin
                                n_state = ST_STATUS;
                            end else begin
                                o_cmd.start = 1'b1;
                                o_cmd.pop   = (i_req_type == REQ_POP);
                                n_state     = ST_ONE;
                            end
                        end
                        REQ_SEARCH: begin
                            if (i_status.empty) begin
                                n_state = ST_STATUS;
                            end else begin
                                o_cmd.start = 1'b1;
                                n_state     = ST_WALK;
                            end
                        end
                        REQ_DISPLAY: begin
                            if (i_status.empty) begin
                                n_state = ST_FINAL;
                            end else begin
                                o_cmd.start = 1'b1;
                                n_state     = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_STATUS: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = (r_req == REQ_PUSH) ? KIND_FULL : KIND_EMPTY;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = (r_req == REQ_POP) ? KIND_POPPED : KIND_PEEKED;
                    o_cmd.data_sel = DATA_MEM;
                    o_cmd.last     = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (r_req == REQ_DISPLAY) begin
                    need           = 1'b1;
                    o_cmd.kind     = KIND_DISPLAY;
                    o_cmd.data_sel = DATA_MEM;
                end else begin
                    need           = i_status.match;
                    o_cmd.kind     = KIND_MATCH_POS;
                    o_cmd.data_sel = DATA_POS;
                end
                if (!need || i_status.out_free) begin
                    o_cmd.emit      = need;
                    o_cmd.count_inc = (r_req == REQ_SEARCH) && i_status.match;
                    if (i_status.at_bottom) begin
                        n_state = ST_FINAL;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    if (r_req == REQ_SEARCH) begin
                        o_cmd.kind     = KIND_MATCH_COUNT;
                        o_cmd.data_sel = DATA_COUNT;
                    end else begin
                        o_cmd.kind = KIND_DISPLAY;
                        o_cmd.dend = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/lss_dpath.sv
`default_nettype none

module lss_dpath
    import lss_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic signed [31:0] i_operand,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_result                 o_out_word
);

    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic signed [31:0] r_mem [0:STACK_DEPTH-1];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_key;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [FILL_W-1:0]  r_pos, n_pos;
    logic [FILL_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0]  rd_addr;
    logic               r_out_valid;
    t_result            r_out, n_out;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_fill  = r_fill;
        n_ptr   = r_ptr;
        n_pos   = r_pos;
        n_count = r_count;
        if (i_cmd.push) begin
            n_fill = r_fill + 1'b1;
        end
        if (i_cmd.pop) begin
            n_fill = r_fill - 1'b1;
        end
        if (i_cmd.start) begin
            n_ptr   = ADDR_W'(r_fill - 1'b1);
            n_pos   = FILL_W'(1);
            n_count = '0;
        end
        if (i_cmd.advance) begin
            n_ptr = r_ptr - 1'b1;
            n_pos = r_pos + 1'b1;
        end
        if (i_cmd.count_inc) begin
            n_count = r_count + 1'b1;
        end
        // The read always follows the walk pointer, so r_rdata holds the entry
        // under r_ptr in the same cycle that r_ptr takes its new value.
        rd_addr = n_ptr;
    end

    always_comb begin
        n_out             = '0;
        n_out.result_kind = i_cmd.kind;
        n_out.display_end = i_cmd.dend;
        n_out.last        = i_cmd.last;
        case (i_cmd.data_sel)
            DATA_MEM:   n_out.result_data = r_rdata;
            DATA_POS:   n_out.result_data = 32'(r_pos);
            DATA_COUNT: n_out.result_data = 32'(r_count);
            default:    n_out.result_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[ADDR_W'(r_fill)] <= i_operand;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ptr       <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            r_pos   <= n_pos;
            r_count <= n_count;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= i_operand;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.empty     = (r_fill == '0);
        o_status.full      = (r_fill == FILL_W'(STACK_DEPTH));
        o_status.match     = (r_rdata == r_key);
        o_status.at_bottom = (r_ptr == '0);
        o_status.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

### hdl/lifo_stack_with_search.sv
// Bounded LIFO stack of signed 32-bit words with search and display.
// Push is done in its accepting cycle; pop and peek emit their word from a second state.
// A request answered with empty or full also emits its word from a second state.
// Search and display walk one entry per cycle, pausing while the output register is busy.
// Throughput is bounded by that walk through the single-read-port store.
// Reset (synchronous, active low) empties the stack and drops any pending result.
`default_nettype none

module lifo_stack_with_search
    import lss_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    // Request channel: one word is a request and its operand.
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_req    i_in_word,
    // Result channel: one word is one result, with last on the final one.
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_result      o_out_word
);

    // The controller sequences each request and the datapath holds the
    // store, the fill level, the walk pointer and the output register.
    // A new request is taken as soon as the controller is back in idle,
    // even while the last result still waits in the output register.
    t_cmd    cmd;
    t_status status;

    lss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_word.req_type),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The store is only ever read below the fill level that a request saw, so
    // its entries need no reset and no valid bits.
    lss_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operand   (i_in_word.operand_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### bench/lifo_stack_with_search_test.sv
// Self-checking bench for the bounded LIFO stack with search and display.
// A shadow stack in the bench predicts every result word of each accepted
// request. The checker compares each result word field by field with the
// oldest prediction still waiting.
module lifo_stack_with_search_test
    import lss_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 32;
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int SETTLE       = 80;       // more than a full display walk
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 100;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    // Clock, reset and the two channels. Every input has a known value from
    // time zero.
    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    in_valid    = 1'b0;
    t_req    in_word     = '0;
    logic    out_ready   = 1'b0;
    logic    o_in_ready;
    logic    o_out_valid;
    t_result o_out_word;

    lifo_stack_with_search #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the stack, and the result words it predicts that have
    // not yet come out of the block.
    logic signed [31:0] stacked_words [DEPTH];
    int                 word_count = 0;
    t_result            pending_results [$];
    int                 mismatches = 0;
    int                 cycle_count = 0;

    // Idling control. The test sequence bumps hold_seq to ask the receiver
    // for a long hold-off; no_gaps switches off random idling on both sides.
    logic               no_gaps = 1'b0;
    int                 hold_seq = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 stall_left = 0;
    int                 stall_draw;

    // Most gaps are zero or short, a few are long.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Operands come mostly from a small pool, so that searches find several
    // matches, with the extremes and fully random words mixed in.
    function automatic logic signed [31:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $signed($urandom_range(0, 7)) - 32'sd2;
        if (roll < 80) begin
            case ($urandom_range(0, 3))
                0:       return WORD_MIN;
                1:       return WORD_MAX;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    function automatic void note_result(logic [2:0] kind, logic signed [31:0] data,
                                        logic dend, logic fin);
        t_result r;
        r.result_kind = kind;
        r.result_data = data;
        r.display_end = dend;
        r.last        = fin;
        pending_results.push_back(r);
    endfunction

    // Works out the result words of one accepted request and updates the
    // shadow stack. Positions count from the top of the stack, starting at one.
    function automatic void predict_stack_results(t_req w);
        int          pos;
        int unsigned hits;
        case (w.req_type)
            REQ_PUSH: begin
                if (word_count >= DEPTH) begin
                    note_result(KIND_FULL, 0, 1'b0, 1'b1);
                end else begin
                    stacked_words[word_count] = w.operand_value;
                    word_count++;
                end
            end
            REQ_POP: begin
                if (word_count == 0) begin
                    note_result(KIND_EMPTY, 0, 1'b0, 1'b1);
                end else begin
                    word_count--;
                    note_result(KIND_POPPED, stacked_words[word_count], 1'b0, 1'b1);
                end
            end
            REQ_PEEK: begin
                if (word_count == 0)
                    note_result(KIND_EMPTY, 0, 1'b0, 1'b1);
                else
                    note_result(KIND_PEEKED, stacked_words[word_count - 1], 1'b0, 1'b1);
            end
            REQ_SEARCH: begin
                if (word_count == 0) begin
                    note_result(KIND_EMPTY, 0, 1'b0, 1'b1);
                end else begin
                    hits = 0;
                    for (pos = 0; pos < word_count; pos++) begin
                        if (stacked_words[word_count - 1 - pos] == w.operand_value) begin
                            note_result(KIND_MATCH_POS, pos + 1, 1'b0, 1'b0);
                            hits++;
                        end
                    end
                    note_result(KIND_MATCH_COUNT, hits, 1'b0, 1'b1);
                end
            end
            REQ_DISPLAY: begin
                for (pos = 0; pos < word_count; pos++)
                    note_result(KIND_DISPLAY, stacked_words[word_count - 1 - pos],
                                1'b0, 1'b0);
                note_result(KIND_DISPLAY, 0, 1'b1, 1'b1);
            end
            default: ;  // the unused codes neither answer nor change the stack
        endcase
    endfunction

    // Offers one request word after a random gap and returns at the edge that
    // accepts it. Valid is only lowered when a gap follows, so it is never
    // dropped and raised again within one time step.
    task automatic send_request(logic [2:0] code, logic signed [31:0] operand);
        t_req w;
        int   gap;
        w.req_type      = code;
        w.operand_value = operand;
        gap = random_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_word  <= w;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_stack_results(w);
    endtask

    // The sender pauses until every predicted result word has arrived.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Requests on an empty stack: every one that answers reports empty, and
    // display gives nothing but its end marker. The unused codes are ignored.
    task automatic test_empty_stack();
        send_request(REQ_POP, pick_operand());
        send_request(REQ_PEEK, pick_operand());
        send_request(REQ_SEARCH, 32'sd0);
        send_request(REQ_DISPLAY, pick_operand());
        send_request(3'd5, $signed($urandom()));
        send_request(3'd6, $signed($urandom()));
        send_request(3'd7, $signed($urandom()));
        send_request(REQ_POP, WORD_MAX);
    endtask

    // Extreme operands, repeated keys and a search that finds nothing.
    task automatic test_extreme_words();
        send_request(REQ_PUSH, WORD_MIN);
        send_request(REQ_PUSH, WORD_MAX);
        send_request(REQ_PUSH, 32'sd0);
        send_request(REQ_PUSH, -32'sd1);
        send_request(REQ_PUSH, WORD_MAX);
        send_request(REQ_PEEK, WORD_MIN);
        send_request(REQ_SEARCH, WORD_MAX);
        send_request(REQ_SEARCH, -32'sd1);
        send_request(REQ_SEARCH, WORD_MIN);
        send_request(REQ_SEARCH, 32'sd12345);
        send_request(REQ_DISPLAY, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(REQ_POP, 32'sd0);
        send_request(3'd7, WORD_MAX);
        send_request(REQ_PEEK, 32'sd0);
        send_request(REQ_DISPLAY, WORD_MIN);
    endtask

    // Fills the stack to its limit, pushes against the full stack, walks the
    // whole of it, then empties it again.
    task automatic test_full_stack();
        while (word_count < DEPTH)
            send_request(REQ_PUSH, pick_operand());
        send_request(REQ_PUSH, WORD_MAX);
        send_request(REQ_PUSH, WORD_MIN);
        send_request(REQ_PEEK, 32'sd0);
        send_request(REQ_SEARCH, stacked_words[$urandom_range(0, DEPTH - 1)]);
        send_request(REQ_DISPLAY, 32'sd0);
        while (word_count > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(REQ_PEEK, pick_operand());
            send_request(REQ_POP, pick_operand());
        end
        send_request(REQ_POP, 32'sd0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering requests, among them searches and displays with several result
    // words each, so the block fills up and stalls its input. Afterwards the sender waits for every result.
    task automatic test_receiver_hold_off();
        int n;
        hold_seq <= hold_seq + 1;
        for (n = 0; n < 10; n++)
            send_request(REQ_PUSH, pick_operand());
        for (n = 0; n < 4; n++) begin
            send_request(REQ_PEEK, 32'sd0);
            send_request(REQ_DISPLAY, 32'sd0);
            send_request(REQ_SEARCH, pick_operand());
        end
        wait_for_results();
    endtask

    // Random traffic in phases, each drawn at random: a growing phase that
    // mostly pushes, a shrinking phase that mostly pops, and a mixed phase.
    // One stretch runs with no idling at all.
    task automatic test_random_traffic();
        int          counted;
        int          roll;
        int          phase;
        logic [2:0]  code;
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 30 == 0)
                phase = $urandom_range(0, 2);
            if (counted == 60)
                no_gaps <= 1'b1;
            if (counted == 90)
                no_gaps <= 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                code = 3'($urandom_range(5, 7));
            end else begin
                roll = $urandom_range(0, 99);
                case (phase)
                    0:       code = (roll < 70) ? REQ_PUSH : 3'($urandom_range(1, 4));
                    1:       code = (roll < 55) ? REQ_POP  : 3'($urandom_range(0, 4));
                    default: code = 3'($urandom_range(0, 4));
                endcase
                counted++;
            end
            send_request(code, pick_operand());
        end
    endtask

    // The sequence of tests, then the drain and the verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_stack();
        test_extreme_words();
        wait_for_results();
        test_full_stack();
        test_receiver_hold_off();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver side: a requested long hold-off wins, otherwise random stalls
    // of mostly short length.
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            stall_draw = random_gap();
            if (stall_draw != 0) begin
                stall_left <= stall_draw - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Checks each accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected, expected nothing, actual %0h",
                         $time, o_out_word);
                mismatches++;
            end else begin
                check_field("result_kind", pending_results[0].result_kind,
                            o_out_word.result_kind);
                check_field("result_data", pending_results[0].result_data,
                            o_out_word.result_data);
                check_field("display_end", pending_results[0].display_end,
                            o_out_word.display_end);
                check_field("last", pending_results[0].last, o_out_word.last);
                void'(pending_results.pop_front());
            end
        end
    end

    // A run that hangs ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
